/* sv/qmp_pkg.sv */
// Shared constants, types and the data mask function of the QR module placer.
package qmp_pkg;

  localparam int unsigned MAX_SIDE_DEF = 177;
  localparam int unsigned COORD_W      = 8;
  localparam int unsigned VER_W        = 6;
  localparam int unsigned MASK_W       = 3;
  localparam int unsigned CFG_W        = 6;

  localparam logic [COORD_W-1:0] TIMING_COL = 8'd6;
  // Side minus one of the smallest symbol.
  localparam logic [COORD_W-1:0] EDGE_RST   = 8'd20;
  localparam logic [VER_W-1:0]   VER_MIN    = 6'd1;
  localparam logic [VER_W-1:0]   VER_MAX    = 6'd40;

  localparam logic [1:0] MODE_RESERVE = 2'd0;
  localparam logic [1:0] MODE_PLACE   = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic REG_VERSION = 1'b0;
  localparam logic REG_MASK    = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic restart;
  } cur_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] pair_col;
    logic [COORD_W-1:0] scan_row;
    logic               left_half;
    logic               loaded;
  } cur_state_t;

  // Side length of a version, clamped to the legal version range.
  function automatic logic [COORD_W-1:0] side_of(input logic [VER_W-1:0] ver);
    logic [VER_W-1:0] v;
    v = ver;
    if (v < VER_MIN) v = VER_MIN;
    if (v > VER_MAX) v = VER_MAX;
    return 8'd17 + {v, 2'b00};
  endfunction

  // x / 3 for 8-bit x by reciprocal multiply.
  function automatic logic [COORD_W-1:0] div3(input logic [COORD_W-1:0] x);
    logic [16:0] prod;
    prod = {9'd0, x} * 17'd171;
    return prod[16:9];
  endfunction

  function automatic logic [1:0] mod3(input logic [COORD_W-1:0] x);
    logic [COORD_W-1:0] rem;
    rem = x - 8'(div3(x) * 8'd3);
    return rem[1:0];
  endfunction

  // Reduce a product or sum of two residues (0..4) modulo 3.
  function automatic logic [1:0] red3(input logic [3:0] x);
    logic [1:0] r;
    case (x)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic mask_bit(input logic [MASK_W-1:0] pat,
                                    input logic [COORD_W-1:0] i,
                                    input logic [COORD_W-1:0] j);
    logic [1:0] i3;
    logic [1:0] j3;
    logic [1:0] p3;
    logic [1:0] s3;
    logic       p2;
    logic [COORD_W-1:0] jq;
    logic       m;
    i3 = mod3(i);
    j3 = mod3(j);
    jq = div3(j);
    p3 = red3(4'({2'b00, i3} * {2'b00, j3}));
    s3 = red3({2'b00, i3} + {2'b00, j3});
    p2 = i[0] & j[0];
    case (pat)
      3'd0:    m = ~(i[0] ^ j[0]);
      3'd1:    m = ~i[0];
      3'd2:    m = (j3 == 2'd0);
      3'd3:    m = (s3 == 2'd0);
      3'd4:    m = ~(i[1] ^ jq[0]);
      3'd5:    m = ~p2 && (p3 == 2'd0);
      3'd6:    m = ~(p2 ^ p3[0]);
      default: m = ~(i[0] ^ j[0] ^ p3[0]);
    endcase
    return m;
  endfunction

endpackage

/* sv/qmp_occ_mem.sv */
// Occupancy memory: one row of module flags per word, registered read.
module qmp_occ_mem #(
  parameter int unsigned ROWS  = qmp_pkg::MAX_SIDE_DEF,
  parameter int unsigned WIDTH = qmp_pkg::MAX_SIDE_DEF
) (
  input  logic                    clk_i,
  input  logic                    rd_en_i,
  input  logic [$clog2(ROWS)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]        rd_data_o,
  input  logic                    wr_en_i,
  input  logic [$clog2(ROWS)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]        wr_data_i
);

  logic [WIDTH-1:0] mem [ROWS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

/* sv/qmp_cursor.sv */
// Zigzag cursor over column pairs, right module before left.
module qmp_cursor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qmp_pkg::cur_cmd_t             cmd_i,
  input  logic [qmp_pkg::COORD_W-1:0]   side_i,
  output qmp_pkg::cur_state_t           cur_o
);

  logic [qmp_pkg::COORD_W-1:0] pair_col_q, pair_col_d;
  logic [qmp_pkg::COORD_W-1:0] scan_row_q, scan_row_d;
  logic                        up_q, up_d;
  logic                        left_q, left_d;
  logic                        loaded_q, loaded_d;
  logic                        next_pair;
  logic [qmp_pkg::COORD_W-1:0] pair_m2;

  always_comb begin
    pair_col_d = pair_col_q;
    scan_row_d = scan_row_q;
    up_d       = up_q;
    left_d     = left_q;
    loaded_d   = loaded_q;
    next_pair  = 1'b0;
    pair_m2    = pair_col_q - 8'd2;
    if (cmd_i.restart) begin
      loaded_d = 1'b0;
    end else if (cmd_i.load) begin
      pair_col_d = side_i - 8'd1;
      scan_row_d = side_i - 8'd1;
      up_d       = 1'b1;
      left_d     = 1'b0;
      loaded_d   = 1'b1;
    end else if (cmd_i.step) begin
      if (!left_q) begin
        left_d = 1'b1;
      end else begin
        left_d = 1'b0;
        if (up_q) begin
          if (scan_row_q == '0) next_pair = 1'b1;
          else scan_row_d = scan_row_q - 8'd1;
        end else begin
          if (({1'b0, scan_row_q} + 9'd1) >= {1'b0, side_i}) next_pair = 1'b1;
          else scan_row_d = scan_row_q + 8'd1;
        end
        if (next_pair) begin
          up_d = ~up_q;
          // Hop to the next pair; skip the timing column.
          if (pair_col_q < 8'd3) pair_col_d = '0;
          else if (pair_m2 == qmp_pkg::TIMING_COL) pair_col_d = pair_m2 - 8'd1;
          else pair_col_d = pair_m2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_col_q <= qmp_pkg::EDGE_RST;
      scan_row_q <= qmp_pkg::EDGE_RST;
      up_q       <= 1'b1;
      left_q     <= 1'b0;
      loaded_q   <= 1'b0;
    end else begin
      pair_col_q <= pair_col_d;
      scan_row_q <= scan_row_d;
      up_q       <= up_d;
      left_q     <= left_d;
      loaded_q   <= loaded_d;
    end
  end

  assign cur_o.pair_col  = pair_col_q;
  assign cur_o.scan_row  = scan_row_q;
  assign cur_o.left_half = left_q;
  assign cur_o.loaded    = loaded_q;

endmodule

/* sv/qr_module_placer.sv */
// Top level of the QR module placer: control sequencer, config and result registers.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+-------------------------
//  command | start, busy, mode_i, row_i, col_i, data_byte_i | taken when start && !busy
//  result  | res_valid_o, out_row_o, out_col_o,             | one-cycle strobe
//          | module_bit_o, exhausted_o, last_o              |
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i               | written when cfg_we_i
//
// Each walk position reads its row of the occupancy memory in S_SEEK, then tests it
// and writes it back in S_TEST. A reserve reads its row when the command is taken and
// writes it back in S_RSV_WR; a restart runs a clearing pass over all MAX_SIDE rows,
// and reset starts the same pass; busy stays high meanwhile.
// Results cannot be stalled by the receiver.
module qr_module_placer #(
  parameter int unsigned MAX_SIDE = qmp_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode_i,
  input  logic [qmp_pkg::COORD_W-1:0]   row_i,
  input  logic [qmp_pkg::COORD_W-1:0]   col_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          res_valid_o,
  output logic [qmp_pkg::COORD_W-1:0]   out_row_o,
  output logic [qmp_pkg::COORD_W-1:0]   out_col_o,
  output logic                          module_bit_o,
  output logic                          exhausted_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [qmp_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned ROW_W = $clog2(MAX_SIDE);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RSV_WR,
    S_SEEK,
    S_TEST
  } state_e;

  state_e                        state_q;
  logic [qmp_pkg::VER_W-1:0]     ver_q;
  logic [qmp_pkg::MASK_W-1:0]    mask_q;
  logic [7:0]                    byte_q;
  logic [2:0]                    bit_cnt_q;
  logic [qmp_pkg::COORD_W-1:0]   rsv_row_q;
  logic [qmp_pkg::COORD_W-1:0]   rsv_col_q;
  logic [ROW_W-1:0]              clr_q;
  logic                          res_valid_q;
  logic [qmp_pkg::COORD_W-1:0]   out_row_q;
  logic [qmp_pkg::COORD_W-1:0]   out_col_q;
  logic                          bit_q;
  logic                          exh_q;
  logic                          last_q;

  logic                          accept;
  logic [qmp_pkg::COORD_W-1:0]   side_raw;
  logic [qmp_pkg::COORD_W-1:0]   side;
  logic                          rsv_in_range;
  logic [qmp_pkg::COORD_W-1:0]   test_col;
  logic                          test_free;
  qmp_pkg::cur_cmd_t             cur_cmd;
  qmp_pkg::cur_state_t           cur;

  logic                          rd_en;
  logic [ROW_W-1:0]              rd_addr;
  logic [MAX_SIDE-1:0]           rd_data;
  logic                          wr_en;
  logic [ROW_W-1:0]              wr_addr;
  logic [MAX_SIDE-1:0]           wr_data;
  logic [ROW_W-1:0]              set_col;
  logic [MAX_SIDE-1:0]           set_bit;

  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign side_raw = qmp_pkg::side_of(ver_q);
  assign side     = (side_raw > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : side_raw;

  assign rsv_in_range = (row_i < side) && (col_i < side);
  assign test_col     = cur.pair_col - {7'd0, cur.left_half};
  assign test_free    = (cur.scan_row < side) && (test_col < side)
                        && !rd_data[test_col[ROW_W-1:0]];

  always_comb begin
    cur_cmd.restart = accept && (mode_i == qmp_pkg::MODE_RESTART);
    cur_cmd.load    = accept && (mode_i == qmp_pkg::MODE_PLACE) && !cur.loaded;
    cur_cmd.step    = (state_q == S_TEST);
  end

  qmp_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .side_i (side),
    .cur_o  (cur)
  );

  // Memory port control: clear rows on a clearing pass, or read a row and write it back with a flag set.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur.scan_row[ROW_W-1:0];
    wr_en   = 1'b0;
    wr_addr = cur.scan_row[ROW_W-1:0];
    set_col = test_col[ROW_W-1:0];
    unique case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
      end
      S_IDLE: begin
        if (accept && (mode_i == qmp_pkg::MODE_RESERVE) && rsv_in_range) begin
          rd_en   = 1'b1;
          rd_addr = row_i[ROW_W-1:0];
        end
      end
      S_RSV_WR: begin
        wr_en   = 1'b1;
        wr_addr = rsv_row_q[ROW_W-1:0];
        set_col = rsv_col_q[ROW_W-1:0];
      end
      S_SEEK: begin
        rd_en = (cur.pair_col != '0);
      end
      S_TEST: begin
        wr_en = test_free;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
    set_bit = {{(MAX_SIDE-1){1'b0}}, 1'b1} << set_col;
    wr_data = (state_q == S_CLEAR) ? '0 : (rd_data | set_bit);
  end

  qmp_occ_mem #(
    .ROWS  (MAX_SIDE),
    .WIDTH (MAX_SIDE)
  ) u_occ_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ver_q       <= qmp_pkg::VER_MIN;
      mask_q      <= '0;
      byte_q      <= '0;
      bit_cnt_q   <= '0;
      rsv_row_q   <= '0;
      rsv_col_q   <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      bit_q       <= 1'b0;
      exh_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          qmp_pkg::REG_VERSION: ver_q  <= cfg_wdata_i[qmp_pkg::VER_W-1:0];
          qmp_pkg::REG_MASK:    mask_q <= cfg_wdata_i[qmp_pkg::MASK_W-1:0];
          default:              ver_q  <= ver_q;
        endcase
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ROW_W'(MAX_SIDE - 1)) begin
            clr_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rsv_row_q <= row_i;
            rsv_col_q <= col_i;
            byte_q    <= data_byte_i;
            bit_cnt_q <= 3'd7;
            case (mode_i)
              qmp_pkg::MODE_RESERVE: if (rsv_in_range) state_q <= S_RSV_WR;
              qmp_pkg::MODE_PLACE:   state_q <= S_SEEK;
              qmp_pkg::MODE_RESTART: state_q <= S_CLEAR;
              default:               state_q <= S_IDLE;
            endcase
          end
        end
        S_RSV_WR: begin
          state_q <= S_IDLE;
        end
        S_SEEK: begin
          if (cur.pair_col == '0) begin
            // Walk finished: drop the rest of the byte.
            res_valid_q <= 1'b1;
            out_row_q   <= '0;
            out_col_q   <= '0;
            bit_q       <= 1'b0;
            exh_q       <= 1'b1;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          state_q <= S_SEEK;
          if (test_free) begin
            res_valid_q <= 1'b1;
            out_row_q   <= cur.scan_row;
            out_col_q   <= test_col;
            bit_q       <= byte_q[bit_cnt_q]
                           ^ qmp_pkg::mask_bit(mask_q, cur.scan_row, test_col);
            exh_q       <= 1'b0;
            last_q      <= (bit_cnt_q == '0);
            bit_cnt_q   <= bit_cnt_q - 3'd1;
            if (bit_cnt_q == '0) state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o  = res_valid_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign module_bit_o = bit_q;
  assign exhausted_o  = exh_q;
  assign last_o       = last_q;

  a_exh_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && exhausted_o |-> last_o)
    else $error("exhausted result not marked last");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("occupancy memory read and written in one cycle");

  a_test_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST) |-> $past(rd_en))
    else $error("row tested without a preceding read");

  a_place_in_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST) && test_free |=> res_valid_o && !exhausted_o)
    else $error("placed module without result");

endmodule
